/* rtl/core/neighbor_table_with_aging_assert.svh */
// Assertion macros for the neighbour table checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH

// same-cycle implication, disabled in reset
`define NTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("neighbour table assertion failed");

// next-cycle implication, disabled in reset
`define NTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("neighbour table assertion failed");

`endif

/* rtl/core/nta_pkg.sv */
// Shared constants and types for the neighbour table with aging.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nta_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_ID_WIDTH    = 48;

  localparam logic [31:0] DEF_TIMEOUT_MS = 32'd12000;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [2:0] EV_IGNORED    = 3'd0;
  localparam logic [2:0] EV_JOINED     = 3'd1;
  localparam logic [2:0] EV_REFRESHED  = 3'd2;
  localparam logic [2:0] EV_FULL       = 3'd3;
  localparam logic [2:0] EV_LEFT       = 3'd4;
  localparam logic [2:0] EV_SWEEP_DONE = 3'd5;

  typedef struct packed {
    logic step;  // ring advances one entry
    logic keep;  // head re-enters at the tail of the live region
    logic wr;    // append at wr_idx
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/neighbor_table_with_aging.sv */
// Neighbour table with timeout aging: controller and ring of nta_cell.
// Depends on nta_pkg and nta_cell.
//
//  channel   handshake                 moves
//  -------   -----------------------   -----------------------------------
//  command   start, busy               action, node id, rssi, time, net id
//  config    cfg_valid_i, cfg_ready_o  register index and data
//  result    res_valid_o (strobe)      event, peer id/rssi, has_peers, last
//
// Hello with foreign net id: result registered in the cycle after the transaction, no busy.
// Other hello: walk in ST_HELLO, result from ST_HELLO_END; sweep: walk in ST_SWEEP, one left result per
// expired entry, then ST_DONE. While walking, the ring moves one entry past the head cell per cycle.
// Reset clears entry count and own net id and loads the default timeout; entry storage needs no clearing.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module neighbor_table_with_aging #(
  parameter int TABLE_DEPTH = nta_pkg::DEF_TABLE_DEPTH,
  parameter int ID_WIDTH    = nta_pkg::DEF_ID_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            action_i,
  input  wire logic        [ID_WIDTH-1:0]      node_id_i,
  input  wire logic signed [7:0]               rssi_i,
  input  wire logic        [31:0]              now_ms_i,
  input  wire logic        [31:0]              net_id_i,
  input  wire logic                            net_id_present_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [nta_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  output logic                                 res_valid_o,
  output logic        [2:0]                    event_res_o,
  output logic        [ID_WIDTH-1:0]           peer_id_o,
  output logic signed [7:0]                    peer_rssi_o,
  output logic                                 has_peers_o,
  output logic                                 last_o
);

  import nta_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_HELLO     = 3'd1;
  localparam logic [2:0] ST_HELLO_END = 3'd2;
  localparam logic [2:0] ST_SWEEP     = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    len_q, len_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic                found_q, found_d;
  logic [31:0]         own_net_q, timeout_q;
  logic [ID_WIDTH-1:0] id_q, id_d;
  logic [7:0]          rssi_q, rssi_d;
  logic [31:0]         now_q, now_d;

  logic                valid_q, valid_d;
  logic [2:0]          evt_q, evt_d;
  logic [ID_WIDTH-1:0] pid_q, pid_d;
  logic [7:0]          prssi_q, prssi_d;
  logic                recent_q, recent_d;
  logic                last_q, last_d;

  logic [ID_WIDTH-1:0] cid  [TABLE_DEPTH];
  logic [7:0]          crssi[TABLE_DEPTH];
  logic [31:0]         cseen[TABLE_DEPTH];

  cell_ctrl_t          ctrl;
  logic [CNT_W-1:0]    cell_len;
  logic [ID_WIDTH-1:0] ld_id;
  logic [7:0]          ld_rssi;
  logic [31:0]         ld_seen;

  logic        accept;
  logic        hit;
  logic        sel_new;
  logic [31:0] age;
  logic        expired;
  logic        last_step;

  assign accept    = start && (state_q == ST_IDLE);
  assign hit       = (cid[0] == id_q);
  assign age       = now_q - cseen[0];
  assign expired   = age > timeout_q;
  assign last_step = (step_q == (cnt_q - CNT_W'(1)));
  assign sel_new   = (state_q == ST_HELLO_END) || ((state_q == ST_HELLO) && hit && !found_q);

  assign ld_id   = sel_new ? id_q   : cid[0];
  assign ld_rssi = sel_new ? rssi_q : crssi[0];
  assign ld_seen = sel_new ? now_q  : cseen[0];

  assign ctrl.step = (state_q == ST_HELLO) || (state_q == ST_SWEEP);
  assign ctrl.keep = (state_q == ST_HELLO) || !expired;
  assign ctrl.wr   = (state_q == ST_HELLO_END) && !found_q && (cnt_q != FULL_CNT);
  assign cell_len  = (state_q == ST_SWEEP) ? len_q : cnt_q;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [ID_WIDTH-1:0] n_id;
    logic [7:0]          n_rssi;
    logic [31:0]         n_seen;

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign n_id   = ld_id;
      assign n_rssi = ld_rssi;
      assign n_seen = ld_seen;
    end else begin : g_mid
      assign n_id   = cid[g+1];
      assign n_rssi = crssi[g+1];
      assign n_seen = cseen[g+1];
    end

    nta_cell #(
      .ID_WIDTH (ID_WIDTH),
      .CNT_W    (CNT_W),
      .IDX      (g)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .len_i      (cell_len),
      .wr_idx_i   (cnt_q),
      .nxt_id_i   (n_id),
      .nxt_rssi_i (n_rssi),
      .nxt_seen_i (n_seen),
      .ld_id_i    (ld_id),
      .ld_rssi_i  (ld_rssi),
      .ld_seen_i  (ld_seen),
      .id_o       (cid[g]),
      .rssi_o     (crssi[g]),
      .seen_o     (cseen[g])
    );
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    step_d   = step_q;
    found_d  = found_q;
    id_d     = id_q;
    rssi_d   = rssi_q;
    now_d    = now_q;
    valid_d  = 1'b0;
    evt_d    = evt_q;
    pid_d    = pid_q;
    prssi_d  = prssi_q;
    recent_d = 1'b0;
    last_d   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          id_d    = node_id_i;
          rssi_d  = rssi_i;
          now_d   = now_ms_i;
          step_d  = '0;
          found_d = 1'b0;
          len_d   = cnt_q;
          if (action_i) begin
            state_d = (cnt_q == '0) ? ST_DONE : ST_SWEEP;
          end else if (net_id_present_i && (net_id_i != own_net_q)) begin
            valid_d = 1'b1;
            evt_d   = EV_IGNORED;
            pid_d   = node_id_i;
            prssi_d = rssi_i;
          end else begin
            state_d = (cnt_q == '0) ? ST_HELLO_END : ST_HELLO;
          end
        end
      end
      ST_HELLO: begin
        found_d = found_q || hit;
        step_d  = step_q + CNT_W'(1);
        if (last_step) begin
          state_d = ST_HELLO_END;
        end
      end
      ST_HELLO_END: begin
        valid_d = 1'b1;
        pid_d   = id_q;
        prssi_d = rssi_q;
        state_d = ST_IDLE;
        if (found_q) begin
          evt_d = EV_REFRESHED;
        end else if (cnt_q == FULL_CNT) begin
          evt_d = EV_FULL;
        end else begin
          evt_d = EV_JOINED;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SWEEP: begin
        step_d = step_q + CNT_W'(1);
        if (expired) begin
          valid_d = 1'b1;
          evt_d   = EV_LEFT;
          pid_d   = cid[0];
          prssi_d = crssi[0];
          last_d  = 1'b0;
          len_d   = len_q - CNT_W'(1);
        end
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        valid_d  = 1'b1;
        evt_d    = EV_SWEEP_DONE;
        pid_d    = '0;
        prssi_d  = '0;
        recent_d = (len_q != '0);
        cnt_d    = len_q;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      valid_q   <= 1'b0;
      own_net_q <= '0;
      timeout_q <= DEF_TIMEOUT_MS;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_OWN_NET: own_net_q <= cfg_data_i;
          CFG_TIMEOUT: timeout_q <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    step_q   <= step_d;
    id_q     <= id_d;
    rssi_q   <= rssi_d;
    now_q    <= now_d;
    evt_q    <= evt_d;
    pid_q    <= pid_d;
    prssi_q  <= prssi_d;
    recent_q <= recent_d;
    last_q   <= last_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign cfg_ready_o  = !busy;
  assign res_valid_o  = valid_q;
  assign event_res_o  = evt_q;
  assign peer_id_o    = pid_q;
  assign peer_rssi_o  = prssi_q;
  assign has_peers_o  = recent_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

/* rtl/core/nta_cell.sv */
// One storage cell of the neighbour ring: id, rssi and last-heard time.
// Depends on nta_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module nta_cell #(
  parameter int ID_WIDTH = 48,
  parameter int CNT_W    = 5,
  parameter int IDX      = 0
) (
  input  wire logic                   clk_i,
  input  wire nta_pkg::cell_ctrl_t    ctrl_i,
  input  wire logic [CNT_W-1:0]       len_i,
  input  wire logic [CNT_W-1:0]       wr_idx_i,
  input  wire logic [ID_WIDTH-1:0]    nxt_id_i,
  input  wire logic [7:0]             nxt_rssi_i,
  input  wire logic [31:0]            nxt_seen_i,
  input  wire logic [ID_WIDTH-1:0]    ld_id_i,
  input  wire logic [7:0]             ld_rssi_i,
  input  wire logic [31:0]            ld_seen_i,
  output logic      [ID_WIDTH-1:0]    id_o,
  output logic      [7:0]             rssi_o,
  output logic      [31:0]            seen_o
);

  localparam logic [CNT_W-1:0] POS  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS1 = CNT_W'(IDX + 1);

  logic [ID_WIDTH-1:0] id_q;
  logic [7:0]          rssi_q;
  logic [31:0]         seen_q;

  logic shift_en;
  logic load_en;

  assign shift_en = ctrl_i.step && (POS1 < len_i);
  assign load_en  = (ctrl_i.step && ctrl_i.keep && (POS1 == len_i)) ||
                    (ctrl_i.wr && (POS == wr_idx_i));

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      id_q   <= nxt_id_i;
      rssi_q <= nxt_rssi_i;
      seen_q <= nxt_seen_i;
    end else if (load_en) begin
      id_q   <= ld_id_i;
      rssi_q <= ld_rssi_i;
      seen_q <= ld_seen_i;
    end
  end

  assign id_o   = id_q;
  assign rssi_o = rssi_q;
  assign seen_o = seen_q;

endmodule

`default_nettype wire

/* rtl/core/nta_checker.sv */
// Port-level checks for the neighbour table, bound to the top level.
// Depends on nta_pkg and neighbor_table_with_aging_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "neighbor_table_with_aging_assert.svh"

module nta_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       action_i,
  input wire logic       res_valid_o,
  input wire logic [2:0] event_res_o,
  input wire logic       has_peers_o,
  input wire logic       last_o
);

  import nta_pkg::*;

  // a sweep transaction always occupies the block
  `NTA_ASSERT_NXT(a_sweep_busy, clk_i, rst_ni, start && !busy && action_i, busy)

  // only left events precede the final result
  `NTA_ASSERT_IMP(a_only_left_mid, clk_i, rst_ni, res_valid_o && !last_o, event_res_o == EV_LEFT)

  // a non-final result means the sweep is still running
  `NTA_ASSERT_IMP(a_mid_busy, clk_i, rst_ni, res_valid_o && !last_o, busy)

  // has_peers only on the sweep summary
  `NTA_ASSERT_IMP(a_recent_done, clk_i, rst_ni, res_valid_o && has_peers_o,
                  event_res_o == EV_SWEEP_DONE && last_o)

endmodule

bind neighbor_table_with_aging nta_checker u_nta_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .action_i     (action_i),
  .res_valid_o  (res_valid_o),
  .event_res_o  (event_res_o),
  .has_peers_o  (has_peers_o),
  .last_o       (last_o)
);

`default_nettype wire

/* tb/neighbor_table_with_aging_tb.sv */
`timescale 1ns / 1ps
// Testbench for neighbor_table_with_aging: directed hello, full-table and sweep
// checks, then random traffic under several idle patterns and register values.
// Depends on nta_pkg and the neighbor_table_with_aging RTL.

module neighbor_table_with_aging_tb;
  import nta_pkg::*;

  localparam int TBL_DEPTH     = DEF_TABLE_DEPTH;
  localparam int ID_W          = DEF_ID_WIDTH;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = TBL_DEPTH + 8;
  localparam int POOL_SIZE     = 24;

  typedef struct {
    logic [2:0]      ev;
    logic [ID_W-1:0] id;
    logic [7:0]      rssi;
    logic            recent;
    logic            last;
  } nbr_event_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 action_i;
  logic [ID_W-1:0]      node_id_i;
  logic signed [7:0]    rssi_i;
  logic [31:0]          now_ms_i;
  logic [31:0]          net_id_i;
  logic                 net_id_present_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;
  logic                 res_valid_o;
  logic [2:0]           event_res_o;
  logic [ID_W-1:0]      peer_id_o;
  logic signed [7:0]    peer_rssi_o;
  logic                 has_peers_o;
  logic                 last_o;

  // neighbour table as the block should hold it
  logic [ID_W-1:0] nbr_id   [TBL_DEPTH];
  logic [7:0]      nbr_rssi [TBL_DEPTH];
  logic [31:0]     nbr_seen [TBL_DEPTH];
  int              nbr_count;
  logic [31:0]     own_net;
  logic [31:0]     age_limit;
  nbr_event_t      expected_events[$];

  int          error_count = 0;
  int          cycle_count = 0;
  int          idle_pct;
  logic [31:0] sim_ms;

  neighbor_table_with_aging i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .node_id_i        (node_id_i),
    .rssi_i           (rssi_i),
    .now_ms_i         (now_ms_i),
    .net_id_i         (net_id_i),
    .net_id_present_i (net_id_present_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .res_valid_o      (res_valid_o),
    .event_res_o      (event_res_o),
    .peer_id_o        (peer_id_o),
    .peer_rssi_o      (peer_rssi_o),
    .has_peers_o      (has_peers_o),
    .last_o           (last_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void note_error(string msg);
    if (error_count < 10) $display("ERROR: %s", msg);
    error_count++;
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ID_W-1:0];
  endfunction

  function automatic void push_event(logic [2:0] ev, logic [ID_W-1:0] id, logic [7:0] rssi,
                                     logic recent, logic last);
    nbr_event_t e;
    e.ev = ev;
    e.id = id;
    e.rssi = rssi;
    e.recent = recent;
    e.last = last;
    expected_events.insert(expected_events.size(), e);
  endfunction

  function automatic void update_table(logic act, logic [ID_W-1:0] id, logic [7:0] rssi,
                                       logic [31:0] now, logic [31:0] net_v, logic present);
    int keep;
    logic [31:0] age;
    if (!act) begin
      if (present && net_v != own_net) begin
        push_event(EV_IGNORED, id, rssi, 1'b0, 1'b1);
        return;
      end
      for (int i = 0; i < nbr_count; i++) begin
        if (nbr_id[i] == id) begin
          nbr_seen[i] = now;
          nbr_rssi[i] = rssi;
          push_event(EV_REFRESHED, id, rssi, 1'b0, 1'b1);
          return;
        end
      end
      if (nbr_count >= TBL_DEPTH) begin
        push_event(EV_FULL, id, rssi, 1'b0, 1'b1);
      end else begin
        nbr_id[nbr_count] = id;
        nbr_rssi[nbr_count] = rssi;
        nbr_seen[nbr_count] = now;
        nbr_count++;
        push_event(EV_JOINED, id, rssi, 1'b0, 1'b1);
      end
    end else begin
      keep = 0;
      for (int i = 0; i < nbr_count; i++) begin
        age = now - nbr_seen[i];
        if (age > age_limit) begin
          push_event(EV_LEFT, nbr_id[i], nbr_rssi[i], 1'b0, 1'b0);
        end else begin
          nbr_id[keep] = nbr_id[i];
          nbr_rssi[keep] = nbr_rssi[i];
          nbr_seen[keep] = nbr_seen[i];
          keep++;
        end
      end
      nbr_count = keep;
      push_event(EV_SWEEP_DONE, '0, 8'h00, keep > 0, 1'b1);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    nbr_event_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_events.size() == 0) begin
        note_error($sformatf("unexpected result: ev %0d id %h rssi %0d recent %b last %b",
                             event_res_o, peer_id_o, peer_rssi_o, has_peers_o, last_o));
      end else begin
        want = expected_events.pop_front();
        if (event_res_o !== want.ev || peer_id_o !== want.id || peer_rssi_o !== want.rssi ||
            has_peers_o !== want.recent || last_o !== want.last)
          note_error($sformatf({"exp ev %0d id %h rssi %0d recent %b last %b, ",
                                "got ev %0d id %h rssi %0d recent %b last %b"},
                               want.ev, want.id, $signed(want.rssi), want.recent, want.last,
                               event_res_o, peer_id_o, peer_rssi_o, has_peers_o, last_o));
      end
    end
  end

  // entered and left at a falling edge; start stays high after the transaction
  task automatic send_item(logic act, logic [ID_W-1:0] id, logic [7:0] rssi,
                           logic [31:0] now, logic [31:0] net_v, logic present);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    node_id_i <= id;
    rssi_i <= rssi;
    now_ms_i <= now;
    net_id_i <= net_v;
    net_id_present_i <= present;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    update_table(act, id, rssi, now, net_v, present);
    @(negedge clk_i);
  endtask

  task automatic drain(int extra);
    start <= 1'b0;
    @(negedge clk_i);
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_OWN_NET) own_net = data;
    else age_limit = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_hello_paths();
    idle_pct = 0;
    send_item(1'b0, '0, 8'h80, 32'd100, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b0, '1, 8'h7F, 32'd200, 32'h0, 1'b1);
    send_item(1'b0, '1, 8'hFF, 32'd300, 32'h1, 1'b1);
    send_item(1'b0, '0, 8'h00, 32'd400, 32'hA5A5_5A5A, 1'b0);
    send_item(1'b1, '0, 8'h00, 32'd12300, 32'h0, 1'b0);
    // age equal to the timeout survives
    send_item(1'b1, '0, 8'h00, 32'd12400, 32'h0, 1'b0);
  endtask

  task automatic test_table_full();
    idle_pct = 0;
    for (int i = 1; i < TBL_DEPTH; i++)
      send_item(1'b0, rand_id(), 8'($urandom), 32'd12500 + i, $urandom, 1'b0);
    send_item(1'b0, rand_id(), 8'($urandom), 32'd12550, 32'h0, 1'b1);
    send_item(1'b0, '0, 8'h80, 32'd12600, 32'h0, 1'b1);
    // time wrapped back to zero: every entry looks ancient
    send_item(1'b1, '0, 8'h00, 32'd0, 32'h0, 1'b0);
  endtask

  task automatic test_timeout_extremes();
    idle_pct = 0;
    drain(SETTLE_CYCLES);
    write_reg(CFG_TIMEOUT, 32'h0);
    write_reg(CFG_OWN_NET, 32'hFFFF_FFFF);
    send_item(1'b0, 48'hA5, 8'hFB, 32'd50, 32'hFFFF_FFFF, 1'b1);
    send_item(1'b0, 48'h5A, 8'h05, 32'd51, 32'h0, 1'b0);
    send_item(1'b1, '0, 8'h00, 32'd51, 32'h0, 1'b0);
    drain(SETTLE_CYCLES);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    send_item(1'b1, '0, 8'h00, 32'd50, 32'h0, 1'b0);
  endtask

  task automatic test_random(int n_items, int idle, int step_max, logic [31:0] start_ms,
                             logic [31:0] net_cfg, logic [31:0] timeout_cfg);
    logic [ID_W-1:0] pool [POOL_SIZE];
    int counted;
    int pick;
    bit paused;
    logic act;
    logic present;
    logic [31:0] net_v;
    drain(SETTLE_CYCLES);
    write_reg(CFG_OWN_NET, net_cfg);
    write_reg(CFG_TIMEOUT, timeout_cfg);
    idle_pct = idle;
    sim_ms = start_ms;
    counted = 0;
    paused = 0;
    for (int k = 0; k < POOL_SIZE; k++) pool[k] = rand_id();
    while (counted < n_items) begin
      if (counted == n_items / 2 && !paused) begin
        drain(0);
        paused = 1;
      end
      pick = $urandom_range(0, 99);
      sim_ms += $urandom_range(0, step_max);
      if (pick < 10) begin
        act = 1'($urandom_range(0, 1));
        present = 1'($urandom_range(0, 1));
        net_v = $urandom;
        send_item(act, rand_id(), 8'($urandom), $urandom, net_v, present);
        if (act || !present || net_v == own_net) counted++;
      end else if (pick < 22) begin
        send_item(1'b1, rand_id(), 8'($urandom), sim_ms, $urandom, 1'($urandom_range(0, 1)));
        counted++;
      end else if (pick < 30) begin
        net_v = own_net ^ ($urandom | 32'h1);
        send_item(1'b0, pool[$urandom_range(0, POOL_SIZE - 1)], 8'($urandom), sim_ms, net_v,
                  1'b1);
      end else begin
        present = 1'($urandom_range(0, 1));
        net_v = present ? own_net : $urandom;
        send_item(1'b0, pool[$urandom_range(0, POOL_SIZE - 1)], 8'($urandom), sim_ms, net_v,
                  present);
        counted++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    action_i = 1'b0;
    node_id_i = '0;
    rssi_i = '0;
    now_ms_i = '0;
    net_id_i = '0;
    net_id_present_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_OWN_NET;
    cfg_data_i = '0;
    idle_pct = 0;
    sim_ms = '0;
    nbr_count = 0;
    own_net = '0;
    age_limit = DEF_TIMEOUT_MS;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_hello_paths();
    test_table_full();
    test_timeout_extremes();
    test_random(45, 0, 1000, 32'd1000, $urandom, 32'd5000);
    test_random(35, 59, 2, $urandom, 32'hFFFF_FFFF, 32'h0);
    test_random(35, 14, 4000, 32'hFFFF_8000, 32'h0, 32'd20000);
    test_random(10, 0, 100000, $urandom, $urandom, 32'hFFFF_FFFF);

    drain(SETTLE_CYCLES);
    error_count += expected_events.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
